@@ rtl/core/planar_palette_remapper_defines.svh @@
// Assertion macros shared by the remapper RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef PLANAR_PALETTE_REMAPPER_DEFINES_SVH
`define PLANAR_PALETTE_REMAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is ignored while reset is asserted.
`define PPR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define PPR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define PPR_ASSERT(label, prop, msg)
`define PPR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ rtl/core/ppr_pkg.sv @@
package ppr_pkg;

    // Sizes fixed by the item and result fields.
    localparam int unsigned PAL_ENTRIES = 256;
    localparam int unsigned IDX_W       = $clog2(PAL_ENTRIES);
    localparam int unsigned PIX_PER_WORD = 16;
    localparam int unsigned PIX_IDX_W   = $clog2(PIX_PER_WORD);
    localparam int unsigned MAX_PLANES  = 8;
    localparam int unsigned PLANE_CNT_W = 4;
    localparam int unsigned COMP_W      = 8;
    localparam int unsigned DIST_W      = 18;

    // Starting distance of a search; any real distance is below it.
    localparam logic [DIST_W-1:0] DIST_START = 18'd200000;

    // Item kinds.
    localparam logic [1:0] KIND_SCREEN  = 2'd0;
    localparam logic [1:0] KIND_PICTURE = 2'd1;
    localparam logic [1:0] KIND_PIXELS  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OLD_PLANES  = 2'd0;
    localparam logic [1:0] CFG_NEW_PLANES  = 2'd1;
    localparam logic [1:0] CFG_USE_PALETTE = 2'd2;

    // Device color order for 16-color and 4-color screens.
    localparam logic [IDX_W-1:0] DEV_ORDER4 [16] = '{
        8'd0, 8'd15, 8'd1, 8'd2, 8'd4, 8'd6, 8'd3, 8'd5,
        8'd7, 8'd8, 8'd9, 8'd10, 8'd12, 8'd14, 8'd11, 8'd13
    };
    localparam logic [IDX_W-1:0] DEV_ORDER2 [4] = '{8'd0, 8'd3, 8'd1, 8'd2};

    // Control of the shared distance unit.
    typedef struct packed {
        logic clear;  // start a new search
        logic step;   // accumulate one color component
        logic last;   // final component: compare against the best so far
    } t_dist_ctl;

    // Plane counts above the maximum saturate.
    function automatic logic [PLANE_CNT_W-1:0] sat_planes(input logic [PLANE_CNT_W-1:0] v);
        return (v > PLANE_CNT_W'(MAX_PLANES)) ? PLANE_CNT_W'(MAX_PLANES) : v;
    endfunction

    // Maps a screen index to the device color number.
    function automatic logic [IDX_W-1:0] device_order(input logic [PLANE_CNT_W-1:0] planes,
                                                      input logic [IDX_W-1:0] j);
        logic [IDX_W-1:0] res;
        res = j;
        if (planes == 4'd2) begin
            res = DEV_ORDER2[j[1:0]];
        end else if (planes == 4'd4) begin
            res = DEV_ORDER4[j[3:0]];
        end else if (planes == 4'd8) begin
            if (j == 8'd1) begin
                res = 8'd255;
            end else if (j == 8'd255) begin
                res = 8'd15;
            end else if (j < 8'd16) begin
                res = DEV_ORDER4[j[3:0]];
            end
        end
        return res;
    endfunction

endpackage

@@ rtl/core/ppr_screen.sv @@
// Screen palette storage: one write port, one registered read port.
module ppr_screen (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [ppr_pkg::IDX_W-1:0]      i_waddr,
    input  logic [3*ppr_pkg::COMP_W-1:0]   i_wdata,
    input  logic                           i_re,
    input  logic [ppr_pkg::IDX_W-1:0]      i_raddr,
    output logic [3*ppr_pkg::COMP_W-1:0]   o_rdata
);

    logic [3*ppr_pkg::COMP_W-1:0] r_mem [ppr_pkg::PAL_ENTRIES];
    logic [3*ppr_pkg::COMP_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ppr_chart.sv @@
// Color chart: a memory plus one valid bit per entry. An entry that was
// never written since reset reads back as its own index.
module ppr_chart (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [ppr_pkg::IDX_W-1:0]  i_waddr,
    input  logic [ppr_pkg::IDX_W-1:0]  i_wdata,
    input  logic                       i_re,
    input  logic [ppr_pkg::IDX_W-1:0]  i_raddr,
    output logic [ppr_pkg::IDX_W-1:0]  o_rdata
);

    logic [ppr_pkg::IDX_W-1:0]       r_mem [ppr_pkg::PAL_ENTRIES];
    logic [ppr_pkg::PAL_ENTRIES-1:0] r_vld;
    logic [ppr_pkg::IDX_W-1:0]       r_mem_q;
    logic [ppr_pkg::IDX_W-1:0]       r_addr_q;
    logic                            r_vld_q;

    // Valid bits are cleared by reset and set by each write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Storage write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read of data, valid bit and address.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_mem_q  <= r_mem[i_raddr];
            r_vld_q  <= r_vld[i_raddr];
            r_addr_q <= i_raddr;
        end
    end

    assign o_rdata = r_vld_q ? r_mem_q : r_addr_q;

endmodule

@@ rtl/core/ppr_dist.sv @@
// Shared distance unit. One color component per step: absolute difference,
// square and accumulate. On the last component the sum is compared with the
// best so far; a strictly lower sum wins, so the first lowest index stays.
module ppr_dist (
    input  logic                        i_clk,
    input  ppr_pkg::t_dist_ctl          i_ctl,
    input  logic [ppr_pkg::COMP_W-1:0]  i_a,
    input  logic [ppr_pkg::COMP_W-1:0]  i_b,
    input  logic [ppr_pkg::IDX_W-1:0]   i_idx,
    output logic [ppr_pkg::IDX_W-1:0]   o_win
);

    logic [ppr_pkg::DIST_W-1:0]   r_acc;
    logic [ppr_pkg::DIST_W-1:0]   r_best;
    logic [ppr_pkg::IDX_W-1:0]    r_win;
    logic [ppr_pkg::COMP_W-1:0]   w_diff;
    logic [2*ppr_pkg::COMP_W-1:0] w_sq;
    logic [ppr_pkg::DIST_W-1:0]   w_sum;

    // Square of the component difference added to the running sum.
    always_comb begin
        w_diff = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
        w_sq   = {8'd0, w_diff} * {8'd0, w_diff};
        w_sum  = r_acc + {2'd0, w_sq};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc  <= '0;
            r_best <= ppr_pkg::DIST_START;
            r_win  <= '0;
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                r_acc <= '0;
                if (w_sum < r_best) begin
                    r_best <= w_sum;
                    r_win  <= i_idx;
                end
            end else begin
                r_acc <= w_sum;
            end
        end
    end

    assign o_win = r_win;

endmodule

@@ rtl/core/planar_palette_remapper.sv @@
// Planar palette remapper. Screen palette writes, unused kinds and pixel
// words with no valid pixel go straight to the result register. A picture
// palette write searches the 2^new_planes active screen entries (at most
// 256) with one shared square-and-accumulate unit: each entry is read from
// the screen palette, then its color components go in one per cycle. A
// pixel word handles its valid pixels one at a time, each with a read of the
// single read port of the color chart and then a write to the new planes.
// The input stalls while an item is in work; a finished result sits in an
// output register, so the next item is taken while it waits. Configuration
// is always ready and must be written only while the block is idle.
`include "planar_palette_remapper_defines.svh"

module planar_palette_remapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_entry_index,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic [63:0] i_source_words_low,
    input  logic [63:0] i_source_words_high,
    input  logic [4:0]  i_pixels_valid,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_mapped_index,
    output logic [63:0] o_dest_words_low,
    output logic [63:0] o_dest_words_high,
    // Configuration channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRD    = 3'd1;
    localparam logic [2:0] S_COMP   = 3'd2;
    localparam logic [2:0] S_MAP    = 3'd3;
    localparam logic [2:0] S_PIX_RD = 3'd4;
    localparam logic [2:0] S_PIX_WR = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [1:0] PH_RED   = 2'd0;
    localparam logic [1:0] PH_GREEN = 2'd1;
    localparam logic [1:0] PH_BLUE  = 2'd2;

    localparam int unsigned IDX_W  = ppr_pkg::IDX_W;
    localparam int unsigned PLN    = ppr_pkg::MAX_PLANES;
    localparam int unsigned PIXW   = ppr_pkg::PIX_PER_WORD;
    localparam int unsigned PIDX_W = ppr_pkg::PIX_IDX_W;
    localparam int unsigned PCW    = ppr_pkg::PLANE_CNT_W;

    // Configuration registers.
    logic [PCW-1:0] r_old_planes;
    logic [PCW-1:0] r_new_planes;
    logic           r_use_palette;

    // Sequencer and item registers.
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [1:0]        r_phase;
    logic [IDX_W-1:0]  r_j;
    logic [IDX_W-1:0]  r_idx;
    logic [7:0]        r_red;
    logic [7:0]        r_green;
    logic [7:0]        r_blue;
    logic [IDX_W-1:0]  r_mapped;
    logic [PIXW-1:0]   r_src [PLN];
    logic [PIXW-1:0]   r_dst [PLN];
    logic [PIDX_W-1:0] r_n;
    logic [PIDX_W:0]   r_cnt;

    // Output register.
    logic        r_out_valid;
    logic [7:0]  r_o_mapped;
    logic [63:0] r_o_dlo;
    logic [63:0] r_o_dhi;

    logic                      w_accept;
    logic                      w_load;
    logic [PCW-1:0]            w_op;
    logic [PCW-1:0]            w_np;
    logic [IDX_W:0]            w_count;
    logic [IDX_W-1:0]          w_last_j;
    logic [PIDX_W:0]           w_cnt_in;
    logic [IDX_W-1:0]          w_old;
    logic [IDX_W-1:0]          w_colour;
    logic [ppr_pkg::COMP_W-1:0] w_scr_comp;
    logic [ppr_pkg::COMP_W-1:0] w_tgt_comp;
    logic [23:0]               w_scr_q;
    logic [IDX_W-1:0]          w_chart_q;
    logic [IDX_W-1:0]          w_win;
    ppr_pkg::t_dist_ctl        w_dist_ctl;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_load      = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_planes  <= 4'd4;
            r_new_planes  <= 4'd4;
            r_use_palette <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ppr_pkg::CFG_OLD_PLANES) begin
                r_old_planes <= i_cfg_data;
            end
            if (i_cfg_index == ppr_pkg::CFG_NEW_PLANES) begin
                r_new_planes <= i_cfg_data;
            end
            if (i_cfg_index == ppr_pkg::CFG_USE_PALETTE) begin
                r_use_palette <= i_cfg_data[0];
            end
        end
    end

    // Saturated plane counts, last active screen entry, valid pixel count.
    always_comb begin
        w_op     = ppr_pkg::sat_planes(r_old_planes);
        w_np     = ppr_pkg::sat_planes(r_new_planes);
        w_count  = (IDX_W+1)'(1) << w_np;
        w_last_j = IDX_W'(w_count - (IDX_W+1)'(1));
        w_cnt_in = (i_pixels_valid > 5'(PIXW)) ? 5'(PIXW) : i_pixels_valid;
    end

    // Gather the old color index of pixel r_n from the source planes.
    always_comb begin
        w_old = '0;
        for (int p = 0; p < PLN; p++) begin
            if (PCW'(p) < w_op) begin
                w_old[p] = r_src[p][~r_n];
            end
        end
        w_colour = r_use_palette ? w_chart_q : w_old;
    end

    // Component fed to the distance unit in each phase.
    always_comb begin
        unique case (r_phase)
            PH_RED: begin
                w_scr_comp = w_scr_q[23:16];
                w_tgt_comp = r_red;
            end
            PH_GREEN: begin
                w_scr_comp = w_scr_q[15:8];
                w_tgt_comp = r_green;
            end
            PH_BLUE: begin
                w_scr_comp = w_scr_q[7:0];
                w_tgt_comp = r_blue;
            end
            default: begin
                w_scr_comp = '0;
                w_tgt_comp = '0;
            end
        endcase
    end

    always_comb begin
        w_dist_ctl.clear = w_accept && (i_kind == ppr_pkg::KIND_PICTURE);
        w_dist_ctl.step  = (r_state == S_COMP);
        w_dist_ctl.last  = (r_phase == PH_BLUE);
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == ppr_pkg::KIND_PICTURE) begin
                        n_state = S_SRD;
                    end else if (i_kind == ppr_pkg::KIND_PIXELS && w_cnt_in != '0) begin
                        n_state = S_PIX_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SRD: begin
                n_state = S_COMP;
            end
            S_COMP: begin
                if (r_phase == PH_BLUE) begin
                    n_state = (r_j == w_last_j) ? S_MAP : S_SRD;
                end
            end
            S_MAP: begin
                n_state = S_DONE;
            end
            S_PIX_RD: begin
                n_state = S_PIX_WR;
            end
            S_PIX_WR: begin
                n_state = ((PIDX_W+1)'(r_n) + 1'b1 == r_cnt) ? S_DONE : S_PIX_RD;
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_RED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_COMP) begin
                r_phase <= (r_phase == PH_BLUE) ? PH_RED : r_phase + 2'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload, counters and destination words.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx    <= i_entry_index;
            r_red    <= i_red;
            r_green  <= i_green;
            r_blue   <= i_blue;
            r_j      <= '0;
            r_n      <= '0;
            r_cnt    <= w_cnt_in;
            r_mapped <= '0;
            for (int p = 0; p < 4; p++) begin
                r_src[p]     <= i_source_words_low[PIXW*p +: PIXW];
                r_src[p + 4] <= i_source_words_high[PIXW*p +: PIXW];
                r_dst[p]     <= '0;
                r_dst[p + 4] <= '0;
            end
        end else begin
            if (r_state == S_COMP && r_phase == PH_BLUE && r_j != w_last_j) begin
                r_j <= r_j + 1'b1;
            end
            if (r_state == S_MAP) begin
                r_mapped <= ppr_pkg::device_order(w_np, w_win);
            end
            // Scatter the color of pixel r_n, mapped through the chart when it is on, into the active planes.
            if (r_state == S_PIX_WR) begin
                for (int p = 0; p < PLN; p++) begin
                    if (PCW'(p) < w_np && w_colour[p]) begin
                        r_dst[p][~r_n] <= 1'b1;
                    end
                end
                r_n <= r_n + 1'b1;
            end
        end
    end

    // Result register, loaded when the previous result has been taken.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_mapped <= r_mapped;
            r_o_dlo    <= {r_dst[3], r_dst[2], r_dst[1], r_dst[0]};
            r_o_dhi    <= {r_dst[7], r_dst[6], r_dst[5], r_dst[4]};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_mapped_index    = r_o_mapped;
    assign o_dest_words_low  = r_o_dlo;
    assign o_dest_words_high = r_o_dhi;

    ppr_screen u_screen (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_kind == ppr_pkg::KIND_SCREEN),
        .i_waddr (i_entry_index),
        .i_wdata ({i_red, i_green, i_blue}),
        .i_re    (r_state == S_SRD),
        .i_raddr (r_j),
        .o_rdata (w_scr_q)
    );

    ppr_chart u_chart (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (r_state == S_MAP),
        .i_waddr (r_idx),
        .i_wdata (ppr_pkg::device_order(w_np, w_win)),
        .i_re    (r_state == S_PIX_RD),
        .i_raddr (w_old),
        .o_rdata (w_chart_q)
    );

    ppr_dist u_dist (
        .i_clk (i_clk),
        .i_ctl (w_dist_ctl),
        .i_a   (w_scr_comp),
        .i_b   (w_tgt_comp),
        .i_idx (r_j),
        .o_win (w_win)
    );

    // The search never runs past the last active screen entry.
    `PPR_ASSERT(a_search_bound, (r_state == S_COMP) |-> (r_j <= w_last_j), "search index out of range")
    // Pixel work stays inside the valid pixel count.
    `PPR_ASSERT(a_pixel_bound, (r_state == S_PIX_RD) |-> ((PIDX_W+1)'(r_n) < r_cnt), "pixel past count")
    // A result appears only after the sequencer finished an item.
    `PPR_ASSERT(a_result_src, $rose(r_out_valid) |-> $past(r_state == S_DONE), "stray result")
    // The component phase counter never reaches its unused code.
    `PPR_ASSERT(a_phase_range, r_phase != 2'd3, "bad component phase")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // A cycle count with no transfer on any channel that ends the run. The slowest
    // item is a picture write that searches 256 screen entries.
    localparam int unsigned IDLE_LIMIT   = 20000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned FAR_DISTANCE = 200000;
    localparam int unsigned MAX_SHOWN    = 30;

    // The kind value that the block leaves unused.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Device color numbers for 16-color and 4-color screens.
    localparam logic [7:0] ORDER_16 [16] = '{
        8'd0, 8'd15, 8'd1, 8'd2, 8'd4, 8'd6, 8'd3, 8'd5,
        8'd7, 8'd8, 8'd9, 8'd10, 8'd12, 8'd14, 8'd11, 8'd13
    };
    localparam logic [7:0] ORDER_4 [4] = '{8'd0, 8'd3, 8'd1, 8'd2};

    // Register settings of the random part: old planes, new planes, chart on, items.
    localparam int unsigned PHASES = 13;
    localparam int unsigned PLAN [PHASES][4] = '{
        '{4, 4, 1, 200}, '{8, 8, 1, 150}, '{1, 1, 1, 100}, '{0, 0, 1, 80},
        '{15, 15, 0, 80}, '{2, 2, 1, 150}, '{3, 5, 1, 150}, '{8, 2, 1, 150},
        '{5, 8, 1, 100}, '{12, 3, 1, 150}, '{6, 6, 0, 100}, '{7, 7, 1, 150},
        '{4, 9, 1, 100}
    };

    typedef struct packed {
        logic [7:0]  mapped_index;
        logic [63:0] dest_low;
        logic [63:0] dest_high;
    } t_remap_result;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  entry;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [63:0] src_low;
        logic [63:0] src_high;
        logic [4:0]  count;
    } t_remap_item;

    // Tracks the palettes and registers, predicts the result of every accepted
    // item and compares the results in order.
    class remap_ledger;
        logic [23:0]   screen [256];
        logic [7:0]    chart [256];
        logic [3:0]    old_count;
        logic [3:0]    new_count;
        logic          chart_on;
        t_remap_result due_results [$];
        int unsigned   errors;
        int unsigned   checked;
        int unsigned   kind_seen [4];

        function new();
            int i;
            for (i = 0; i < 256; i++) begin
                screen[i] = '0;
                chart[i]  = i[7:0];
            end
            for (i = 0; i < 4; i++) begin
                kind_seen[i] = 0;
            end
            old_count = 4'd4;
            new_count = 4'd4;
            chart_on  = 1'b0;
            errors    = 0;
            checked   = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [3:0] data);
            case (index)
                ppr_pkg::CFG_OLD_PLANES:  old_count = data;
                ppr_pkg::CFG_NEW_PLANES:  new_count = data;
                ppr_pkg::CFG_USE_PALETTE: chart_on = data[0];
                default: ;
            endcase
        endfunction

        function void accept_item(logic [1:0] kind, logic [7:0] entry, logic [7:0] red,
                                  logic [7:0] green, logic [7:0] blue,
                                  logic [63:0] src_low, logic [63:0] src_high,
                                  logic [4:0] count);
            t_remap_result exp;
            logic [127:0]  src;
            logic [127:0]  dst;
            logic [7:0]    gathered;
            logic [7:0]    colour;
            int unsigned   planes_in;
            int unsigned   planes_out;
            int unsigned   entries;
            int unsigned   best;
            int unsigned   win;
            int unsigned   pixels;
            int            dr;
            int            dg;
            int            db;
            int            sq_dist;
            int            j;
            int            n;
            int            p;

            exp        = '0;
            planes_in  = (old_count > 4'd8) ? 8 : old_count;
            planes_out = (new_count > 4'd8) ? 8 : new_count;
            case (kind)
                ppr_pkg::KIND_SCREEN: begin
                    screen[entry] = {red, green, blue};
                end
                ppr_pkg::KIND_PICTURE: begin
                    // Nearest active screen entry; a later entry must be strictly closer.
                    entries = (planes_out >= 8) ? 256 : (1 << planes_out);
                    best    = FAR_DISTANCE;
                    win     = 0;
                    for (j = 0; j < entries; j++) begin
                        dr      = int'(screen[j][23:16]) - int'(red);
                        dg      = int'(screen[j][15:8]) - int'(green);
                        db      = int'(screen[j][7:0]) - int'(blue);
                        sq_dist = dr * dr + dg * dg + db * db;
                        if (sq_dist < best) begin
                            best = sq_dist;
                            win  = j;
                        end
                    end
                    // Screen index to device color number.
                    exp.mapped_index = 8'(win);
                    if (planes_out == 2) begin
                        exp.mapped_index = ORDER_4[win % 4];
                    end else if (planes_out == 4) begin
                        exp.mapped_index = ORDER_16[win % 16];
                    end else if (planes_out == 8) begin
                        if (win == 1) begin
                            exp.mapped_index = 8'd255;
                        end else if (win == 255) begin
                            exp.mapped_index = 8'd15;
                        end else if (win < 16) begin
                            exp.mapped_index = ORDER_16[win];
                        end
                    end
                    chart[entry] = exp.mapped_index;
                end
                ppr_pkg::KIND_PIXELS: begin
                    // Gather leading pixels, remap if the chart is on, scatter to the new planes.
                    src    = {src_high, src_low};
                    dst    = '0;
                    pixels = (count > 5'd16) ? 16 : count;
                    for (n = 0; n < pixels; n++) begin
                        gathered = '0;
                        for (p = 0; p < planes_in; p++) begin
                            gathered[p] = src[16 * p + 15 - n];
                        end
                        colour = chart_on ? chart[gathered] : gathered;
                        for (p = 0; p < planes_out; p++) begin
                            dst[16 * p + 15 - n] = colour[p];
                        end
                    end
                    exp.dest_low  = dst[63:0];
                    exp.dest_high = dst[127:64];
                end
                default: ;
            endcase
            kind_seen[kind]++;
            due_results.push_back(exp);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("%0t ns: %s mismatch, expected %h, actual %h",
                             $time, field, want, seen);
                end
            end
        endfunction

        function void compare_result(logic [7:0] mapped, logic [63:0] dest_low,
                                     logic [63:0] dest_high);
            t_remap_result exp;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN) begin
                    $display("%0t ns: unexpected result, expected none, actual %h %h %h",
                             $time, mapped, dest_low, dest_high);
                end
                return;
            end
            exp = due_results.pop_front();
            checked++;
            compare_field("mapped_index", 64'(exp.mapped_index), 64'(mapped));
            compare_field("dest_words_low", exp.dest_low, dest_low);
            compare_field("dest_words_high", exp.dest_high, dest_high);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_kind;
    logic [7:0]  i_entry_index;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [63:0] i_source_words_low;
    logic [63:0] i_source_words_high;
    logic [4:0]  i_pixels_valid;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_mapped_index;
    logic [63:0] o_dest_words_low;
    logic [63:0] o_dest_words_high;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [3:0]  i_cfg_data;

    remap_ledger ledger;
    logic [23:0] screen_rgb [256];
    bit          screen_set [256];
    logic [3:0]  cur_new;
    bit          calm;
    int unsigned idle_cycles;

    planar_palette_remapper dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_entry_index       (i_entry_index),
        .i_red               (i_red),
        .i_green             (i_green),
        .i_blue              (i_blue),
        .i_source_words_low  (i_source_words_low),
        .i_source_words_high (i_source_words_high),
        .i_pixels_valid      (i_pixels_valid),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_mapped_index      (o_mapped_index),
        .o_dest_words_low    (o_dest_words_low),
        .o_dest_words_high   (o_dest_words_high),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // 4 ns clock.
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Every transfer is observed here; the watchdog counts edges without one.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                ledger.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !o_in_stall) begin
                ledger.accept_item(i_kind, i_entry_index, i_red, i_green, i_blue,
                                   i_source_words_low, i_source_words_high, i_pixels_valid);
            end
            if (o_out_valid && !i_out_stall) begin
                ledger.compare_result(o_mapped_index, o_dest_words_low, o_dest_words_high);
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
                (o_out_valid && !i_out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no transfer in %0d cycles, %0d results outstanding",
                         $time, IDLE_LIMIT, ledger.due_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Result side: stall at random before each transfer, never in a calm stretch.
    initial begin : result_pacing
        int unsigned hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 3);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    function automatic logic [63:0] random_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '1;
        end else if (roll == 1) begin
            return '0;
        end
        return {$urandom, $urandom};
    endfunction

    function automatic logic [4:0] random_count();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            return 5'd0;
        end else if (roll == 1) begin
            return 5'd16;
        end else if (roll < 4) begin
            return 5'($urandom_range(17, 31));
        end
        return 5'($urandom_range(1, 16));
    endfunction

    // Components lean toward the ends of their range.
    function automatic logic [23:0] random_colour();
        logic [23:0] rgb;
        int          c;
        int unsigned roll;
        for (c = 0; c < 3; c++) begin
            roll = $urandom_range(0, 7);
            rgb[8 * c +: 8] = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 :
                              8'($urandom_range(0, 255));
        end
        return rgb;
    endfunction

    // Fields that the kind does not use still carry random values.
    function automatic t_remap_item scrambled_item();
        t_remap_item it;
        it.kind     = KIND_UNUSED;
        it.entry    = 8'($urandom_range(0, 255));
        it.red      = 8'($urandom_range(0, 255));
        it.green    = 8'($urandom_range(0, 255));
        it.blue     = 8'($urandom_range(0, 255));
        it.src_low  = {$urandom, $urandom};
        it.src_high = {$urandom, $urandom};
        it.count    = 5'($urandom_range(0, 31));
        return it;
    endfunction

    function automatic int unsigned active_entries();
        return (cur_new >= 4'd8) ? 256 : (1 << cur_new);
    endfunction

    // One input transfer after a random gap; valid stays high when there is no gap.
    task automatic send_item(t_remap_item it);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_kind              <= it.kind;
        i_entry_index       <= it.entry;
        i_red               <= it.red;
        i_green             <= it.green;
        i_blue              <= it.blue;
        i_source_words_low  <= it.src_low;
        i_source_words_high <= it.src_high;
        i_pixels_valid      <= it.count;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic screen_write(int unsigned entry, logic [23:0] rgb);
        t_remap_item it;
        it       = scrambled_item();
        it.kind  = ppr_pkg::KIND_SCREEN;
        it.entry = 8'(entry);
        {it.red, it.green, it.blue} = rgb;
        screen_rgb[entry] = rgb;
        screen_set[entry] = 1'b1;
        send_item(it);
    endtask

    // A search may only cover written screen entries, so any gap is filled first.
    task automatic picture_write(int unsigned entry, logic [23:0] rgb);
        t_remap_item it;
        int unsigned j;
        for (j = 0; j < active_entries(); j++) begin
            if (!screen_set[j]) begin
                screen_write(j, random_colour());
            end
        end
        it       = scrambled_item();
        it.kind  = ppr_pkg::KIND_PICTURE;
        it.entry = 8'(entry);
        {it.red, it.green, it.blue} = rgb;
        send_item(it);
    endtask

    task automatic pixel_word(logic [63:0] low, logic [63:0] high, logic [4:0] count);
        t_remap_item it;
        it          = scrambled_item();
        it.kind     = ppr_pkg::KIND_PIXELS;
        it.src_low  = low;
        it.src_high = high;
        it.count    = count;
        send_item(it);
    endtask

    task automatic unused_item();
        send_item(scrambled_item());
    endtask

    // Waits until every expected result has arrived and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (ledger.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all three registers back to back; the block is idle here.
    task automatic configure(logic [3:0] old_n, logic [3:0] new_n, logic chart_on);
        logic [1:0] reg_id [3];
        logic [3:0] value [3];
        int         r;
        reg_id[0] = ppr_pkg::CFG_OLD_PLANES;
        reg_id[1] = ppr_pkg::CFG_NEW_PLANES;
        reg_id[2] = ppr_pkg::CFG_USE_PALETTE;
        value[0]  = old_n;
        value[1]  = new_n;
        value[2]  = {3'($urandom_range(0, 7)), chart_on};
        for (r = 0; r < 3; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= reg_id[r];
            i_cfg_data  <= value[r];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        cur_new = (new_n > 4'd8) ? 4'd8 : new_n;
    endtask

    // Mostly pixel words, with palette writes and unused items mixed in; colors are often copied
    // from the screen palette to produce exact matches and ties.
    task automatic random_phase(int unsigned items, int unsigned picture_pct);
        int unsigned k;
        int unsigned roll;
        int unsigned src;
        logic [23:0] rgb;
        for (k = 0; k < items; k++) begin
            if (k % 40 == 0) begin
                calm = ($urandom_range(0, 4) == 0);
            end
            roll = $urandom_range(0, 99);
            rgb  = random_colour();
            if (roll < 20) begin
                src = $urandom_range(0, 255);
                if ($urandom_range(0, 4) == 0 && screen_set[src]) begin
                    rgb = screen_rgb[src];
                end
                screen_write($urandom_range(0, 255), rgb);
            end else if (roll < 20 + picture_pct) begin
                src = $urandom_range(0, active_entries() - 1);
                if ($urandom_range(0, 2) == 0 && screen_set[src]) begin
                    rgb = screen_rgb[src] ^ ($urandom_range(0, 1) ? 24'h010101 : 24'h0);
                end
                picture_write($urandom_range(0, 255), rgb);
            end else if (roll < 95) begin
                pixel_word(random_word(), random_word(), random_count());
            end else begin
                unused_item();
            end
        end
    endtask

    initial begin : stimulus
        int unsigned k;
        int unsigned ph;
        ledger              = new();
        calm                = 1'b0;
        cur_new             = 4'd4;
        idle_cycles         = 0;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_kind              = '0;
        i_entry_index       = '0;
        i_red               = '0;
        i_green             = '0;
        i_blue              = '0;
        i_source_words_low  = '0;
        i_source_words_high = '0;
        i_pixels_valid      = '0;
        i_out_stall         = 1'b0;
        i_cfg_valid         = 1'b0;
        i_cfg_index         = '0;
        i_cfg_data          = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset settings: black and white screen entries,
        // a duplicated color for a tie, exact matches at both ends of the chart,
        // and pixel counts of zero, one, sixteen and above sixteen, then an unused item.
        screen_write(0, 24'h000000);
        screen_write(15, 24'hFFFFFF);
        for (k = 1; k < 15; k++) begin
            screen_write(k, (k == 7) ? screen_rgb[2] : random_colour());
        end
        picture_write(0, 24'h000000);
        picture_write(255, 24'hFFFFFF);
        picture_write(9, screen_rgb[2]);
        picture_write(128, random_colour());
        pixel_word('1, '1, 5'd16);
        pixel_word(random_word(), random_word(), 5'd0);
        pixel_word(random_word(), random_word(), 5'd31);
        pixel_word(random_word(), random_word(), 5'd1);
        unused_item();
        drain();

        // Random part over a range of register settings, saturating counts included.
        for (ph = 0; ph < PHASES; ph++) begin
            configure(4'(PLAN[ph][0]), 4'(PLAN[ph][1]), PLAN[ph][2] != 0);
            random_phase(PLAN[ph][3], (cur_new >= 4'd7) ? 6 : 20);
            drain();
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d screen writes, %0d picture writes, %0d pixel words,",
                 ledger.checked, ledger.kind_seen[ppr_pkg::KIND_SCREEN],
                 ledger.kind_seen[ppr_pkg::KIND_PICTURE],
                 ledger.kind_seen[ppr_pkg::KIND_PIXELS]);
        $display("%0d unused-kind items, over %0d register settings with and without the chart.",
                 ledger.kind_seen[KIND_UNUSED], PHASES + 1);
        if (ledger.errors == 0 && ledger.due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
